FILE: rtl/i2cbm_pkg.sv
// ----------------------------------------------------------------------------
// i2cbm_pkg
// Shared types and constants of the bit-level I2C master: command codes,
// register indexes, reset values and the item payloads of both channels.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

   localparam int BYTE_BITS = 8;
   localparam int BIT_W     = $clog2(BYTE_BITS);
   localparam logic [BIT_W-1:0] BIT_MAX = BIT_W'(BYTE_BITS - 1);

   localparam int HALF_W  = 10;
   localparam int POLLT_W = 10;
   localparam int LIMIT_W = 12;
   localparam int CSR_W   = 12;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_HALF_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POLL_TICKS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POLL_LIMIT  = 2'd2;

   localparam logic [HALF_W-1:0]  HALF_PERIOD_RESET = 10'd5;
   localparam logic [POLLT_W-1:0] POLL_TICKS_RESET  = 10'd10;
   localparam logic [LIMIT_W-1:0] POLL_LIMIT_RESET  = 12'd300;

   localparam logic [2:0] CMD_START   = 3'd0;
   localparam logic [2:0] CMD_STOP    = 3'd1;
   localparam logic [2:0] CMD_WRITE   = 3'd2;
   localparam logic [2:0] CMD_READ    = 3'd3;
   localparam logic [2:0] CMD_WAITACK = 3'd4;
   localparam logic [2:0] CMD_ACK     = 3'd5;
   localparam logic [2:0] CMD_NOACK   = 3'd6;

   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_ISSUE = 1'b1;

   typedef struct packed {
      logic                 req_type;
      logic [2:0]           command;
      logic [BYTE_BITS-1:0] tx_byte;
      logic                 sda_in;
   } req_item_type;

   typedef struct packed {
      logic                 scl_out;
      logic                 sda_out;
      logic                 busy_res;
      logic                 done_res;
      logic [BYTE_BITS-1:0] rx_byte;
      logic                 ack_seen;
      logic                 ack_timeout;
   } rsp_item_type;

endpackage

FILE: rtl/i2cbm_req_if.sv
// ----------------------------------------------------------------------------
// i2cbm_req_if
// Valid/ready channel carrying tick and issue items into the master.
// ----------------------------------------------------------------------------
interface i2cbm_req_if;
   import i2cbm_pkg::*;

   logic         valid;
   logic         ready;
   req_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/i2cbm_rsp_if.sv
// ----------------------------------------------------------------------------
// i2cbm_rsp_if
// Valid/ready channel carrying result items out of the master.
// ----------------------------------------------------------------------------
interface i2cbm_rsp_if;
   import i2cbm_pkg::*;

   logic         valid;
   logic         ready;
   rsp_item_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/i2c_bit_level_master_top.sv
// ----------------------------------------------------------------------------
// i2c_bit_level_master_top
// Bit-level I2C master: commands stepped through SCL/SDA phases by tick items.
// ----------------------------------------------------------------------------
// One item in, one result item out. An issue item starts start, stop, write
// byte, read byte, wait ack, give ack or give no-ack; tick items then walk
// the command through its line phases, each phase held for half_period_ticks
// ticks (wait ack polls SDA every ack_poll_ticks ticks, at most
// ack_poll_limit polls). The block takes one item per clock cycle unless
// both registers hold items and rsp_chan is not ready: the item is captured
// in an input register, the phase machine advances in one pass of short
// logic, and the result lands in an output register. As these are separate
// stages, a new item enters an empty input register while a result waits.
// Registers are written through csr_we/csr_index/csr_wdata; the user writes
// them only while the block is idle (not enforced); a zero value acts as one.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_top (
   input  logic                             clock,
   input  logic                             reset,
   i2cbm_req_if.sink                        req_chan,
   i2cbm_rsp_if.source                      rsp_chan,
   input  logic                             csr_we,
   input  logic [i2cbm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [i2cbm_pkg::CSR_W-1:0]      csr_wdata
);
   import i2cbm_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WAIT1,
      PH_WAIT2,
      PH_LOW,
      PH_HIGH,
      PH_POLL
   } phase_type;

   // configuration
   logic [HALF_W-1:0]  half_ff;
   logic [POLLT_W-1:0] pollt_ff;
   logic [LIMIT_W-1:0] limit_ff;

   // pipeline stages
   logic         s1_valid_ff;
   req_item_type s1_item_ff;
   logic         s2_valid_ff;
   rsp_item_type s2_item_ff;
   logic         s1_move;

   // command state
   phase_type            phase_ff, phase_in;
   logic [2:0]           cmd_ff, cmd_in;
   logic [HALF_W-1:0]    tick_ff, tick_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [BYTE_BITS-1:0] shift_ff, shift_in;
   logic [LIMIT_W-1:0]   poll_ff, poll_in;
   logic                 scl_ff, scl_in;
   logic                 sda_ff, sda_in;
   logic [1:0]           flags_ff, flags_in;
   logic [BYTE_BITS-1:0] rx_ff, rx_in;
   logic                 done_in;

   // tick counting helpers
   logic [HALF_W-1:0]  period;
   logic [HALF_W-1:0]  period_min;
   logic [HALF_W-1:0]  tick_inc;
   logic               expire;
   logic [LIMIT_W-1:0] poll_inc;
   logic [LIMIT_W-1:0] limit_min;
   logic [BIT_W-1:0]   bit_next;
   logic               more_bits;
   rsp_item_type       rsp_in;

   // the result stage frees up when empty or being taken
   assign s1_move        = !s2_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s1_move;

   assign rsp_chan.valid   = s2_valid_ff;
   assign rsp_chan.payload = s2_item_ff;

   assign period     = (phase_ff == PH_POLL) ? pollt_ff : half_ff;
   assign period_min = (period == '0) ? HALF_W'(1) : period;
   assign tick_inc   = tick_ff + HALF_W'(1);
   assign expire     = (tick_inc >= period_min);
   assign poll_inc   = poll_ff + LIMIT_W'(1);
   assign limit_min  = (limit_ff == '0) ? LIMIT_W'(1) : limit_ff;
   assign bit_next   = bit_ff + BIT_W'(1);
   assign more_bits  = ((cmd_ff == CMD_WRITE) || (cmd_ff == CMD_READ)) && (bit_ff != BIT_MAX);

   // one step of the phase machine for the item in the input register
   always_comb begin
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      poll_in  = poll_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      flags_in = flags_ff;
      rx_in    = rx_ff;
      done_in  = 1'b0;

      if (s1_item_ff.req_type == REQ_ISSUE) begin
         // issue while busy, or code seven, is dropped
         if (phase_ff == PH_IDLE && s1_item_ff.command <= CMD_NOACK) begin
            cmd_in  = s1_item_ff.command;
            tick_in = '0;
            bit_in  = '0;
            case (s1_item_ff.command)
               CMD_START: begin
                  sda_in = 1'b1; scl_in = 1'b1; phase_in = PH_WAIT1;
               end
               CMD_STOP: begin
                  sda_in = 1'b0; scl_in = 1'b1; phase_in = PH_WAIT1;
               end
               CMD_WRITE: begin
                  shift_in = s1_item_ff.tx_byte;
                  scl_in   = 1'b0;
                  sda_in   = s1_item_ff.tx_byte[BIT_MAX];
                  phase_in = PH_LOW;
               end
               CMD_READ: begin
                  shift_in = '0; scl_in = 1'b0; sda_in = 1'b1; phase_in = PH_LOW;
               end
               CMD_WAITACK: begin
                  flags_in = 2'b00; poll_in = '0;
                  scl_in = 1'b0; sda_in = 1'b1; phase_in = PH_LOW;
               end
               CMD_ACK: begin
                  scl_in = 1'b0; sda_in = 1'b0; phase_in = PH_LOW;
               end
               default: begin
                  scl_in = 1'b0; sda_in = 1'b1; phase_in = PH_LOW;
               end
            endcase
         end
      end else if (phase_ff != PH_IDLE) begin
         tick_in = expire ? '0 : tick_inc;
         if (expire) begin
            case (phase_ff)
               PH_WAIT1: begin
                  sda_in   = (cmd_ff != CMD_START);
                  phase_in = PH_WAIT2;
               end
               PH_WAIT2: begin
                  if (cmd_ff == CMD_START) scl_in = 1'b0;
                  phase_in = PH_IDLE;
                  done_in  = 1'b1;
               end
               PH_LOW: begin
                  scl_in   = 1'b1;
                  phase_in = PH_HIGH;
                  if (cmd_ff == CMD_READ) begin
                     shift_in = {shift_ff[BYTE_BITS-2:0], s1_item_ff.sda_in};
                  end else if (cmd_ff == CMD_WAITACK) begin
                     if (!s1_item_ff.sda_in) flags_in = 2'b01;
                     else phase_in = PH_POLL;
                  end
               end
               PH_POLL: begin
                  poll_in = poll_inc;
                  if (poll_inc >= limit_min) begin
                     flags_in = 2'b10; phase_in = PH_HIGH;
                  end else if (!s1_item_ff.sda_in) begin
                     flags_in = 2'b01; phase_in = PH_HIGH;
                  end
               end
               PH_HIGH: begin
                  scl_in = 1'b0;
                  if (more_bits) begin
                     bit_in   = bit_next;
                     sda_in   = (cmd_ff == CMD_WRITE) ? shift_ff[BIT_MAX - bit_next] : 1'b1;
                     phase_in = PH_LOW;
                  end else begin
                     if (cmd_ff == CMD_READ) rx_in = shift_ff;
                     phase_in = PH_IDLE;
                     done_in  = 1'b1;
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end
      end

      rsp_in.scl_out     = scl_in;
      rsp_in.sda_out     = sda_in;
      rsp_in.busy_res    = (phase_in != PH_IDLE);
      rsp_in.done_res    = done_in;
      rsp_in.rx_byte     = rx_in;
      rsp_in.ack_seen    = flags_in[0];
      rsp_in.ack_timeout = flags_in[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff     <= HALF_PERIOD_RESET;
         pollt_ff    <= POLL_TICKS_RESET;
         limit_ff    <= POLL_LIMIT_RESET;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         phase_ff    <= PH_IDLE;
         cmd_ff      <= CMD_START;
         tick_ff     <= '0;
         bit_ff      <= '0;
         shift_ff    <= '0;
         poll_ff     <= '0;
         scl_ff      <= 1'b1;
         sda_ff      <= 1'b1;
         flags_ff    <= 2'b00;
         rx_ff       <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_HALF_PERIOD: half_ff  <= csr_wdata[HALF_W-1:0];
               CSR_POLL_TICKS:  pollt_ff <= csr_wdata[POLLT_W-1:0];
               CSR_POLL_LIMIT:  limit_ff <= csr_wdata[LIMIT_W-1:0];
               default: ;
            endcase
         end

         // input register
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
            if (req_chan.valid) s1_item_ff <= req_chan.payload;
         end

         // state advances as the item moves into the result register
         if (s1_move) begin
            s2_valid_ff <= s1_valid_ff;
            if (s1_valid_ff) begin
               s2_item_ff <= rsp_in;
               phase_ff   <= phase_in;
               cmd_ff     <= cmd_in;
               tick_ff    <= tick_in;
               bit_ff     <= bit_in;
               shift_ff   <= shift_in;
               poll_ff    <= poll_in;
               scl_ff     <= scl_in;
               sda_ff     <= sda_in;
               flags_ff   <= flags_in;
               rx_ff      <= rx_in;
            end
         end
      end
   end

   // a finishing item never reports busy
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && s2_item_ff.done_res |-> !s2_item_ff.busy_res)
      else $error("done reported while busy");

   // acknowledge and timeout are exclusive
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      flags_ff != 2'b11)
      else $error("ack seen and timeout both set");

   // only byte transfers step through bit positions
   a_bit_only_bytes: assert property (@(posedge clock) disable iff (reset)
      bit_ff != '0 |-> (cmd_ff == CMD_WRITE) || (cmd_ff == CMD_READ))
      else $error("bit index moved outside a byte transfer");

   // an item in the input register reaches the result register when free
   a_stage_advance: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_move |=> s2_valid_ff)
      else $error("item lost between stages");

   // state only changes when an item passes into the result register
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !(s1_valid_ff && s1_move) |=> $stable(phase_ff) && $stable(tick_ff))
      else $error("phase state changed without an item");

endmodule

FILE: tb/sv/i2c_bit_level_master_top_tb.sv
// ----------------------------------------------------------------------------
// i2c_bit_level_master_top_tb
// Self-checking bench for the bit-level I2C master. A short stimulus table
// covers reset, ignored items and every short command. Random command
// sequences follow, with read/write bytes, ack polling and timeouts, under
// several register settings and idle patterns. A line-level predictor in the
// bench works out each result item not given in the table, and each result
// is compared with its expected item field by field.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_top_tb;
   import i2cbm_pkg::*;

   // no item moving for this many cycles means the block hung
   localparam int STALL_LIMIT = 4000;
   localparam int DIR_LEN     = 24;
   // stimulus row at which the short-period setting goes in
   localparam int DIR_CFG_ROW = 2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SETUP, ST_FINISH, ST_SCL_LOW, ST_SCL_HIGH, ST_POLL
   } line_phase_type;

   typedef enum int {
      IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH
   } idle_mode_type;

   // one stimulus row: item, whether a literal result is given, that result
   typedef struct packed {
      req_item_type item;
      bit           lit;
      rsp_item_type want;
   } dir_row_type;

   // literal rows: reset levels, both lines released, nothing busy
   localparam dir_row_type DIR_ROWS [0:DIR_LEN-1] = '{
      '{'{REQ_TICK,  CMD_START,   8'h00, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}},
      '{'{REQ_ISSUE, 3'd7,        8'hFF, 1'b1}, 1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}},
      '{'{REQ_ISSUE, CMD_START,   8'h00, 1'b0}, 1'b0, '0},
      '{'{REQ_ISSUE, CMD_WRITE,   8'hA5, 1'b1}, 1'b0, '0},
      '{'{REQ_TICK,  CMD_START,   8'h00, 1'b1}, 1'b0, '0},
      '{'{REQ_TICK,  CMD_START,   8'h00, 1'b0}, 1'b0, '0},
      '{'{REQ_ISSUE, CMD_STOP,    8'hFF, 1'b0}, 1'b0, '0},
      '{'{REQ_TICK,  CMD_START,   8'h00, 1'b1}, 1'b0, '0},
      '{'{REQ_TICK,  CMD_START,   8'h00, 1'b1}, 1'b0, '0},
      '{'{REQ_ISSUE, CMD_ACK,     8'h00, 1'b0}, 1'b0, '0},
      '{'{REQ_TICK,  CMD_START,   8'h00, 1'b1}, 1'b0, '0},
      '{'{REQ_TICK,  CMD_START,   8'h00, 1'b0}, 1'b0, '0},
      '{'{REQ_ISSUE, CMD_NOACK,   8'h5A, 1'b0}, 1'b0, '0},
      '{'{REQ_TICK,  CMD_START,   8'h00, 1'b0}, 1'b0, '0},
      '{'{REQ_TICK,  CMD_START,   8'h00, 1'b1}, 1'b0, '0},
      '{'{REQ_ISSUE, CMD_WAITACK, 8'h00, 1'b0}, 1'b0, '0},
      '{'{REQ_TICK,  CMD_START,   8'h00, 1'b0}, 1'b0, '0},
      '{'{REQ_TICK,  CMD_START,   8'h00, 1'b1}, 1'b0, '0},
      '{'{REQ_ISSUE, CMD_WAITACK, 8'h00, 1'b0}, 1'b0, '0},
      '{'{REQ_TICK,  CMD_START,   8'h00, 1'b1}, 1'b0, '0},
      '{'{REQ_TICK,  CMD_START,   8'h00, 1'b1}, 1'b0, '0},
      '{'{REQ_TICK,  CMD_START,   8'h00, 1'b1}, 1'b0, '0},
      '{'{REQ_TICK,  CMD_START,   8'h00, 1'b0}, 1'b0, '0},
      '{'{REQ_TICK,  CMD_START,   8'h00, 1'b1}, 1'b0, '0}
   };

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   i2cbm_req_if req_chan ();
   i2cbm_rsp_if rsp_chan ();

   i2c_bit_level_master_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bench copy of the registers
   int half_cfg, pollt_cfg, limit_cfg;

   // bench copy of the line state machine
   logic [2:0]     cur_cmd;
   line_phase_type cur_phase;
   logic [9:0]     hold_cnt;
   logic [2:0]     bit_pos;
   logic [7:0]     shifter;
   logic [11:0]    polls;
   logic           scl_lv, sda_lv;
   logic [1:0]     flags;     // bit 0 ack seen, bit 1 timeout
   logic [7:0]     rx_last;

   rsp_item_type pending_rsp [$];

   int req_idle_pct;
   int rsp_stall_pct;
   int active_items;       // items that moved the line state
   int rsp_count;
   int mismatches;

   // ------------------------------------------------------------------
   // line predictor
   // ------------------------------------------------------------------
   function automatic int nz(input int v);
      return (v == 0) ? 1 : v;
   endfunction

   // one tick of a held phase; true when the phase has run out
   function automatic bit hold_done(input int period);
      hold_cnt = hold_cnt + 10'd1;
      if (hold_cnt >= nz(period)) begin
         hold_cnt = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void start_command(input logic [2:0] cmd, input logic [7:0] data);
      // busy or code seven: nothing changes
      if (cur_phase != ST_IDLE || cmd > CMD_NOACK) return;
      cur_cmd  = cmd;
      hold_cnt = '0;
      bit_pos  = '0;
      case (cmd)
         CMD_START: begin
            sda_lv = 1'b1; scl_lv = 1'b1; cur_phase = ST_SETUP;
         end
         CMD_STOP: begin
            sda_lv = 1'b0; scl_lv = 1'b1; cur_phase = ST_SETUP;
         end
         CMD_WRITE: begin
            shifter = data; scl_lv = 1'b0; sda_lv = data[BYTE_BITS-1];
            cur_phase = ST_SCL_LOW;
         end
         CMD_WAITACK: begin
            flags = 2'b00; polls = '0;
            scl_lv = 1'b0; sda_lv = 1'b1; cur_phase = ST_SCL_LOW;
         end
         CMD_ACK: begin
            scl_lv = 1'b0; sda_lv = 1'b0; cur_phase = ST_SCL_LOW;
         end
         default: begin
            // read clears the shifter, give no-ack just releases sda
            if (cmd == CMD_READ) shifter = '0;
            scl_lv = 1'b0; sda_lv = 1'b1; cur_phase = ST_SCL_LOW;
         end
      endcase
   endfunction

   // returns true on the tick at which the command finishes
   function automatic bit tick_command(input logic sda);
      case (cur_phase)
         ST_SETUP: begin
            if (!hold_done(half_cfg)) return 1'b0;
            sda_lv = (cur_cmd == CMD_START) ? 1'b0 : 1'b1;
            cur_phase = ST_FINISH;
            return 1'b0;
         end
         ST_FINISH: begin
            if (!hold_done(half_cfg)) return 1'b0;
            if (cur_cmd == CMD_START) scl_lv = 1'b0;
            cur_phase = ST_IDLE;
            return 1'b1;
         end
         ST_SCL_LOW: begin
            if (!hold_done(half_cfg)) return 1'b0;
            scl_lv = 1'b1;
            cur_phase = ST_SCL_HIGH;
            if (cur_cmd == CMD_READ) shifter = {shifter[BYTE_BITS-2:0], sda};
            else if (cur_cmd == CMD_WAITACK) begin
               if (!sda) flags = 2'b01;
               else cur_phase = ST_POLL;
            end
            return 1'b0;
         end
         ST_POLL: begin
            if (!hold_done(pollt_cfg)) return 1'b0;
            polls = polls + 12'd1;
            if (polls >= nz(limit_cfg)) begin
               flags = 2'b10;
               cur_phase = ST_SCL_HIGH;
            end else if (!sda) begin
               flags = 2'b01;
               cur_phase = ST_SCL_HIGH;
            end
            return 1'b0;
         end
         ST_SCL_HIGH: begin
            if (!hold_done(half_cfg)) return 1'b0;
            scl_lv = 1'b0;
            if ((cur_cmd == CMD_WRITE || cur_cmd == CMD_READ) && bit_pos < BIT_MAX) begin
               bit_pos = bit_pos + 3'd1;
               sda_lv = (cur_cmd == CMD_WRITE) ? shifter[BYTE_BITS-1-bit_pos] : 1'b1;
               cur_phase = ST_SCL_LOW;
               return 1'b0;
            end
            if (cur_cmd == CMD_READ) rx_last = shifter;
            cur_phase = ST_IDLE;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic rsp_item_type master_step(input req_item_type it);
      bit fin;
      fin = 1'b0;
      // issue items never count as ticks
      if (it.req_type == REQ_ISSUE) start_command(it.command, it.tx_byte);
      else fin = tick_command(it.sda_in);
      return '{scl_out: scl_lv, sda_out: sda_lv, busy_res: (cur_phase != ST_IDLE),
               done_res: fin, rx_byte: rx_last, ack_seen: flags[0], ack_timeout: flags[1]};
   endfunction

   // ------------------------------------------------------------------
   // item builders
   // ------------------------------------------------------------------
   function automatic req_item_type tick_item(input logic sda);
      return '{req_type: REQ_TICK, command: 3'($urandom_range(7)),
               tx_byte: 8'($urandom), sda_in: sda};
   endfunction

   function automatic req_item_type issue_item(input logic [2:0] cmd, input logic [7:0] data);
      return '{req_type: REQ_ISSUE, command: cmd, tx_byte: data,
               sda_in: 1'($urandom_range(1))};
   endfunction

   // ------------------------------------------------------------------
   // sender side
   // ------------------------------------------------------------------
   // waits out a random gap, offers the item, predicts on acceptance
   task automatic send_item(input req_item_type it, input bit use_lit = 1'b0,
                            input rsp_item_type lit = '0);
      rsp_item_type pred;
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= it;
      do @(posedge clock); while (!req_chan.ready);
      // ignored items do not count toward the budget
      if (it.req_type == REQ_ISSUE) begin
         if (cur_phase == ST_IDLE && it.command <= CMD_NOACK) active_items++;
      end else if (cur_phase != ST_IDLE) active_items++;
      pred = master_step(it);
      pending_rsp.push_back(use_lit ? lit : pred);
   endtask

   // hold off until every result is back
   task automatic drain();
      req_chan.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // tick a half-done command to its end
   task automatic finish_command();
      while (cur_phase != ST_IDLE) send_item(tick_item(1'($urandom_range(1))));
   endtask

   // caller has drained: block idle, valid low
   task automatic program_regs(input int half, input int pollt, input int limit);
      csr_we    <= 1'b1;
      csr_index <= CSR_HALF_PERIOD;
      csr_wdata <= CSR_W'(half);
      @(posedge clock);
      csr_index <= CSR_POLL_TICKS;
      csr_wdata <= CSR_W'(pollt);
      @(posedge clock);
      csr_index <= CSR_POLL_LIMIT;
      csr_wdata <= CSR_W'(limit);
      @(posedge clock);
      csr_we    <= 1'b0;
      half_cfg  = half & 'h3FF;
      pollt_cfg = pollt & 'h3FF;
      limit_cfg = limit & 'hFFF;
   endtask

   // one command sequence with random content, or a short run of noise
   task automatic run_burst();
      logic [2:0] cmd;
      int         sda_low_pct;
      int         n;
      if ($urandom_range(99) < 15) begin
         // noise: any shape, may leave a command half done
         n = $urandom_range(1, 6);
         repeat (n) begin
            if ($urandom_range(1)) send_item(tick_item(1'($urandom_range(1))));
            else send_item(issue_item(3'($urandom_range(7)), 8'($urandom)));
         end
         return;
      end
      finish_command();
      // now and then the sender waits for the block to catch up
      if ($urandom_range(99) < 5) drain();
      cmd = 3'($urandom_range(CMD_NOACK));
      // how often the slave pulls sda low; never pulling it low gives a timeout
      case ($urandom_range(3))
         0: sda_low_pct = 0;
         1: sda_low_pct = 10;
         2: sda_low_pct = 50;
         default: sda_low_pct = 100;
      endcase
      send_item(issue_item(cmd, 8'($urandom)));
      while (cur_phase != ST_IDLE) begin
         if ($urandom_range(99) < 3)
            send_item(issue_item(3'($urandom_range(7)), 8'($urandom)));   // ignored while busy
         else
            send_item(tick_item(($urandom_range(99) < sda_low_pct) ? 1'b0 : 1'b1));
      end
   endtask

   task automatic run_phase(input int half, input int pollt, input int limit,
                            input idle_mode_type mode, input int budget);
      finish_command();
      drain();
      program_regs(half, pollt, limit);
      case (mode)
         IDLE_NONE:     begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
         IDLE_SENDER:   begin req_idle_pct = 68; rsp_stall_pct = 0;  end
         IDLE_RECEIVER: begin req_idle_pct = 0;  rsp_stall_pct = 68; end
         default:       begin req_idle_pct = 32; rsp_stall_pct = 32; end
      endcase
      active_items = 0;
      while (active_items < budget) run_burst();
   endtask

   // ------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      mismatches++;
      // keep the log short when the block is badly off
      if (mismatches <= 100)
         $display("result %0d: %s is %0h, expected %0h", rsp_count, what, got, want);
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) report_mismatch(name, got, want);
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_count++;
         if (pending_rsp.size() == 0)
            report_mismatch("result with no item pending", 16'(rsp_chan.payload), '0);
         else begin
            want = pending_rsp.pop_front();
            check_field("scl_out",     16'(rsp_chan.payload.scl_out),     16'(want.scl_out));
            check_field("sda_out",     16'(rsp_chan.payload.sda_out),     16'(want.sda_out));
            check_field("busy_res",    16'(rsp_chan.payload.busy_res),    16'(want.busy_res));
            check_field("done_res",    16'(rsp_chan.payload.done_res),    16'(want.done_res));
            check_field("rx_byte",     16'(rsp_chan.payload.rx_byte),     16'(want.rx_byte));
            check_field("ack_seen",    16'(rsp_chan.payload.ack_seen),    16'(want.ack_seen));
            check_field("ack_timeout", 16'(rsp_chan.payload.ack_timeout),
                        16'(want.ack_timeout));
         end
      end
      // receiver stalls at the phase's rate
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // watchdog: ends the run when nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_chan.valid && req_chan.ready) ||
             (rsp_chan.valid && rsp_chan.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("no item moved for %0d cycles, %0d results pending",
               STALL_LIMIT, pending_rsp.size());
      $display("Test completed with failures");
      $finish;
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      // known levels on every input from time zero
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b1;
      csr_we           = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_idle_pct     = 0;
      rsp_stall_pct    = 0;
      active_items     = 0;
      rsp_count        = 0;
      mismatches       = 0;

      // predictor starts from the reset state
      half_cfg  = int'(HALF_PERIOD_RESET);
      pollt_cfg = int'(POLL_TICKS_RESET);
      limit_cfg = int'(POLL_LIMIT_RESET);
      cur_cmd   = CMD_START;
      cur_phase = ST_IDLE;
      hold_cnt  = '0;
      bit_pos   = '0;
      shifter   = '0;
      polls     = '0;
      scl_lv    = 1'b1;
      sda_lv    = 1'b1;
      flags     = 2'b00;
      rx_last   = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // stimulus table: first rows at reset settings, rest at one-tick phases
      for (int r = 0; r < DIR_LEN; r++) begin
         if (r == DIR_CFG_ROW) begin
            drain();
            program_regs(1, 1, 2);
         end
         send_item(DIR_ROWS[r].item, DIR_ROWS[r].lit, DIR_ROWS[r].want);
      end

      // random sequences under several settings
      run_phase(1, 1, 1, IDLE_NONE, 250);
      run_phase(2, 3, 5, IDLE_SENDER, 250);
      run_phase(0, 0, 0, IDLE_RECEIVER, 150);        // zero acts as one
      run_phase(3, 1, 40, IDLE_BOTH, 200);
      run_phase(9, 250, 1, IDLE_NONE, 1);            // long poll interval, one command
      run_phase(7, 2, 3, IDLE_BOTH, 200);
      run_phase(5, 10, 12, IDLE_RECEIVER, 100);

      // let the last command and its results come out
      finish_command();
      drain();
      repeat (10) @(posedge clock);

      if (mismatches == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
